// File: rtl/akbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akbc_pkg - shared types and constants for the alternating key byte cipher
// Word layouts, configuration register indexes and cipher constants.
// ----------------------------------------------------------------------------
package akbc_pkg;

  localparam int TEXT_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int KEY_BYTES = 32;
  localparam int POS_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ARITH_W   = 10;

  // cipher constants
  localparam logic [TEXT_W-1:0]  COMMA_CHAR = 7'd44;
  localparam logic [ARITH_W-1:0] KEY_BIAS   = 10'd48;
  localparam logic [ARITH_W-1:0] WRAP_STEP  = 10'd79;
  localparam logic [ARITH_W-1:0] ADD_LIMIT  = 10'd126;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECRYPT_MODE = 3'd0,
    CFG_KEY_0_7      = 3'd1,
    CFG_KEY_8_15     = 3'd2,
    CFG_KEY_16_23    = 3'd3,
    CFG_KEY_24_31    = 3'd4
  } cfg_reg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [TEXT_W-1:0] text;
    logic [BYTE_W-1:0] key;
    logic              use_add;
    logic              is_comma;
    logic              last;
  } akbc_word_t;

endpackage

// File: rtl/akbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akbc_front - input acceptance, key position tracking and classification
// Holds the configuration registers, selects the key byte and rule per word.
// ----------------------------------------------------------------------------
module akbc_front
  import akbc_pkg::*;
#(
  parameter int KEY_LENGTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic [TEXT_W-1:0]     in_text_byte,
  input  logic                  in_end_of_message,
  input  logic                  q_full,
  output logic                  in_stall,
  output logic                  push,
  output akbc_word_t            push_word
);

  logic                                mode_r;
  logic [KEY_BYTES-1:0][BYTE_W-1:0]    key_r;
  logic [POS_W-1:0]                    pos_r, pos_nxt;
  logic                                accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign push      = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      key_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DECRYPT_MODE: mode_r <= cfg_data[0];
        CFG_KEY_0_7:      key_r[7:0]   <= cfg_data;
        CFG_KEY_8_15:     key_r[15:8]  <= cfg_data;
        CFG_KEY_16_23:    key_r[23:16] <= cfg_data;
        CFG_KEY_24_31:    key_r[31:24] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_end_of_message || pos_r >= POS_W'(KEY_LENGTH - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    push_word.text     = in_text_byte;
    push_word.key      = key_r[pos_r];
    // even position adds when encrypting; decrypt flips the rule
    push_word.use_add  = !pos_r[0] ^ mode_r;
    push_word.is_comma = (in_text_byte == COMMA_CHAR);
    push_word.last     = in_end_of_message;
  end

endmodule

// File: rtl/akbc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akbc_queue - two-entry queue between front and back
// Lets the front keep accepting while the back waits on the output side.
// ----------------------------------------------------------------------------
module akbc_queue
  import akbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  akbc_word_t push_word,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output akbc_word_t head_word
);

  akbc_word_t  mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_word = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// File: rtl/akbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akbc_back - cipher arithmetic and output register
// Applies the add or subtract rule with its wraparound and holds the result.
// ----------------------------------------------------------------------------
module akbc_back
  import akbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              not_empty,
  input  akbc_word_t        head_word,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic                      out_valid_r;
  logic [BYTE_W-1:0]         byte_r, byte_nxt;
  logic                      last_r;
  logic signed [ARITH_W-1:0] t_s, k_s, add_c, sub_c, add_res, sub_res;

  assign pop       = not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

  always_comb begin
    t_s   = signed'({3'b000, head_word.text});
    k_s   = signed'({2'b00, head_word.key});
    add_c = t_s + k_s - signed'(KEY_BIAS);
    sub_c = t_s - k_s + signed'(KEY_BIAS);
    add_res = (add_c > signed'(ADD_LIMIT)) ? add_c - signed'(WRAP_STEP) : add_c;
    sub_res = (sub_c < signed'(KEY_BIAS))  ? sub_c + signed'(WRAP_STEP) : sub_c;
    if (head_word.is_comma) begin
      byte_nxt = {1'b0, head_word.text};
    end else if (head_word.use_add) begin
      byte_nxt = add_res[BYTE_W-1:0];
    end else begin
      byte_nxt = sub_res[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= byte_nxt;
      last_r <= head_word.last;
    end
  end

endmodule

// File: rtl/alternating_key_byte_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_key_byte_cipher_unit - alternating key byte cipher, top level
// Streams 7-bit characters through a 32-byte keyed add/subtract cipher.
// ----------------------------------------------------------------------------
// One word is accepted per clock and one result word leaves per clock when the
// output is not stalled; an accepted input word is written into the queue and,
// once popped, its result is loaded into the output register and presented on
// out_valid. The rate is set by the back stage, which does one add, compare
// and correction per cycle. A two-entry queue and the output register absorb
// up to three words while the output stalls, after which in_stall rises. The
// key position restarts at zero after a word marked end_of_message and after
// position KEY_LENGTH-1. Write the mode and key registers only while idle;
// cfg_ready is always high.
module alternating_key_byte_cipher_unit
  import akbc_pkg::*;
#(
  parameter int KEY_LENGTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TEXT_W-1:0]     in_text_byte,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_last
);

  logic       q_full, q_not_empty, push, pop;
  akbc_word_t push_word, head_word;

  akbc_front #(
    .KEY_LENGTH (KEY_LENGTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_text_byte      (in_text_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .in_stall          (in_stall),
    .push              (push),
    .push_word         (push_word)
  );

  akbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_word (head_word)
  );

  akbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (q_not_empty),
    .head_word (head_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: rtl/akbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akbc_checker - port-level checks for the cipher unit
// Tracks words in flight and checks input and output behavior over time.
// ----------------------------------------------------------------------------
module akbc_checker
  import akbc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last
);

  logic       in_acc, out_acc;
  logic [2:0] inflight_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // no result word without an accepted input word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("output word with nothing in flight");

  // queue plus output register hold at most three words
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd3)
    else $error("more words in flight than storage");

  // an empty block never stalls its input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 3'd0 |-> !in_stall)
    else $error("input stalled while empty");

endmodule

bind alternating_key_byte_cipher_unit akbc_checker u_akbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
